[src/ubfd_pkg.sv]
// ubfd_pkg: shared constants and types for the uart bit frame decoder
// used by ubfd_check and uart_bit_frame_decoder_core
`timescale 1ns / 1ps

package ubfd_pkg;

  // default and bounds of the window length
  localparam int unsigned MaxFrameDef = 16;
  // longest frame the layout can describe: 2 start + 8 data + parity + 2 stop
  localparam int unsigned FrameLenMax = 13;
  localparam int unsigned FrameLenW   = 5;
  localparam int unsigned DataW       = 8;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 4;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t CfgStartBits  = 2'd0;
  localparam cfg_idx_t CfgDataBits   = 2'd1;
  localparam cfg_idx_t CfgParityMode = 2'd2;
  localparam cfg_idx_t CfgStopBits   = 2'd3;

  // parity selector codes
  localparam logic [1:0] ParityOdd  = 2'd1;
  localparam logic [1:0] ParityEven = 2'd2;

  typedef struct packed {
    logic [1:0] start_bits;
    logic [3:0] data_bits;
    logic [1:0] parity_mode;
    logic [1:0] stop_bits;
  } cfg_t;

  localparam cfg_t CfgReset = '{start_bits: 2'd1, data_bits: 4'd8,
                                parity_mode: 2'd0, stop_bits: 2'd1};

endpackage

[src/ubfd_cell.sv]
// ubfd_cell: one position of the bit window, holds a line bit and its fill flag
// depends on nothing outside this file
`timescale 1ns / 1ps

module ubfd_cell (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  logic clear_i,
  input  logic bit_i,
  input  logic fill_i,
  output logic bit_o,
  output logic fill_o
);

  logic bit_q, bit_d;
  logic fill_q, fill_d;

  always_comb begin
    bit_d  = bit_q;
    fill_d = fill_q;
    if (clear_i) begin
      bit_d  = 1'b0;
      fill_d = 1'b0;
    end else if (shift_i) begin
      bit_d  = bit_i;
      fill_d = fill_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= 1'b0;
      fill_q <= 1'b0;
    end else begin
      bit_q  <= bit_d;
      fill_q <= fill_d;
    end
  end

  assign bit_o  = bit_q;
  assign fill_o = fill_q;

endmodule

[src/ubfd_check.sv]
// ubfd_check: frame layout decode, start/stop/parity checks and byte packing
// depends on ubfd_pkg
`timescale 1ns / 1ps

module ubfd_check #(
  parameter int unsigned MaxFrame = ubfd_pkg::MaxFrameDef
) (
  input  ubfd_pkg::cfg_t          cfg_i,
  input  logic [MaxFrame-1:0]     window_i,
  input  logic [MaxFrame-1:0]     fill_i,
  output logic                    frame_ok_o,
  output logic [ubfd_pkg::DataW-1:0] data_byte_o
);

  import ubfd_pkg::*;

  localparam int unsigned ExtW = (MaxFrame > FrameLenMax) ? MaxFrame : FrameLenMax;
  localparam int unsigned IdxW = $clog2(ExtW);

  logic [ExtW-1:0]      win_ext, fill_ext;
  logic [1:0]           ns, nst;
  logic [3:0]           nd;
  logic                 np;
  logic [FrameLenW-1:0] len;
  logic [IdxW-1:0]      start_idx, stop_idx, par_idx, data_base;
  logic [DataW-1:0]     byte_v;
  logic                 ones, parity_ok, too_long;

  assign win_ext  = ExtW'(window_i);
  assign fill_ext = ExtW'(fill_i);

  // clamp the layout fields
  assign ns  = cfg_i.start_bits[1] ? 2'd2 : 2'd1;
  assign nst = cfg_i.stop_bits[1]  ? 2'd2 : 2'd1;
  assign nd  = (cfg_i.data_bits < 4'd5) ? 4'd5 :
               (cfg_i.data_bits > 4'd8) ? 4'd8 : cfg_i.data_bits;
  assign np  = (cfg_i.parity_mode == ParityOdd) || (cfg_i.parity_mode == ParityEven);

  assign len      = FrameLenW'(ns) + FrameLenW'(nd) + FrameLenW'(np) + FrameLenW'(nst);
  assign too_long = len > FrameLenW'(MaxFrame);

  // newest bit sits at index 0, oldest of the frame at len-1
  assign start_idx = IdxW'(len - 1'b1);
  assign stop_idx  = IdxW'(nst - 1'b1);
  assign par_idx   = IdxW'(nst);
  assign data_base = IdxW'(FrameLenW'(nd) + FrameLenW'(np) + FrameLenW'(nst) - 1'b1);

  always_comb begin
    byte_v = '0;
    for (int k = 0; k < DataW; k++) begin
      if (4'(k) < nd) begin
        byte_v[k] = win_ext[data_base - IdxW'(k)];
      end
    end
  end

  assign ones = ^byte_v;

  always_comb begin
    parity_ok = 1'b1;
    if (cfg_i.parity_mode == ParityOdd) begin
      parity_ok = (ones ^ win_ext[par_idx]) == 1'b1;
    end else if (cfg_i.parity_mode == ParityEven) begin
      parity_ok = (ones ^ win_ext[par_idx]) == 1'b0;
    end
  end

  assign frame_ok_o = !too_long && fill_ext[start_idx] && !win_ext[start_idx]
                      && win_ext[stop_idx] && parity_ok;
  assign data_byte_o = byte_v;

endmodule

[src/uart_bit_frame_decoder_core.sv]
// uart_bit_frame_decoder_core: top level of the sliced-bit uart frame decoder
// depends on ubfd_pkg, ubfd_cell and ubfd_check
`timescale 1ns / 1ps

// usage
//   input channel (in_valid_i / in_ready_o / line_bit_i) takes one sampled
//   line bit per request; the bit enters a chain of MaxFrame cells, newest
//   at cell 0, each cell also carrying a fill flag so the chain doubles as
//   the fill count
//   a frame is checked on the window as it stands after the new bit; a good
//   frame yields one request on the output channel (out_valid_o /
//   out_ready_i / data_byte_o) and empties the chain, otherwise nothing is
//   emitted and the window just slides
//   throughput: one line bit per cycle unless stalled; latency: the byte
//   appears in the cycle after the request that completes the frame
//   the result sits in an output register; a new bit is still taken while
//   that register is being drained, so only a held result that the
//   receiver does not take in the same cycle stalls the input
//   reset: layout returns to 1 start, 8 data, no parity, 1 stop, the chain
//   is emptied and the output valid flag is cleared
//   configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
module uart_bit_frame_decoder_core #(
  parameter int unsigned MaxFrame = ubfd_pkg::MaxFrameDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  ubfd_pkg::cfg_idx_t            cfg_index_i,
  input  logic [ubfd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          line_bit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ubfd_pkg::DataW-1:0]    data_byte_o
);

  import ubfd_pkg::*;

  cfg_t              cfg_q, cfg_d;
  logic [MaxFrame-1:0] win_cells, fill_cells;
  logic [MaxFrame-1:0] win_next, fill_next;
  logic                in_take, frame_ok, clear;
  logic [DataW-1:0]    byte_v;
  logic                out_valid_q, out_valid_d;
  logic [DataW-1:0]    data_q, data_d;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgStartBits:  cfg_d.start_bits  = cfg_data_i[1:0];
        CfgDataBits:   cfg_d.data_bits   = cfg_data_i[3:0];
        CfgParityMode: cfg_d.parity_mode = cfg_data_i[1:0];
        CfgStopBits:   cfg_d.stop_bits   = cfg_data_i[1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // input is taken whenever the output register is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_take    = in_valid_i && in_ready_o;

  // window as it will look after the shift, used for the frame check
  assign win_next  = {win_cells[MaxFrame-2:0], line_bit_i};
  assign fill_next = {fill_cells[MaxFrame-2:0], 1'b1};

  // chain of cells, cell 0 takes the new line bit
  for (genvar i = 0; i < MaxFrame; i++) begin : g_cell
    ubfd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_take),
      .clear_i (clear),
      .bit_i   (win_next[i]),
      .fill_i  (fill_next[i]),
      .bit_o   (win_cells[i]),
      .fill_o  (fill_cells[i])
    );
  end

  ubfd_check #(
    .MaxFrame (MaxFrame)
  ) u_check (
    .cfg_i       (cfg_q),
    .window_i    (win_next),
    .fill_i      (fill_next),
    .frame_ok_o  (frame_ok),
    .data_byte_o (byte_v)
  );

  // a good frame empties the window
  assign clear = in_take && frame_ok;

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    data_d      = data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (clear) begin
      out_valid_d = 1'b1;
      data_d      = byte_v;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgReset;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_byte_o = data_q;

endmodule

[tb/sv/uart_bit_frame_decoder_core_tb.sv]
// uart_bit_frame_decoder_core_tb: self-checking bench for the sliced-bit uart frame decoder
// depends on ubfd_pkg and uart_bit_frame_decoder_core; predicts every byte from a
// bit-exact copy of the sliding window and checks it against the output channel
`timescale 1ns / 1ps

module uart_bit_frame_decoder_core_tb;
  import ubfd_pkg::*;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned WinLen      = MaxFrameDef;
  localparam int unsigned CycleLimit  = 200000;
  // byte shows up the cycle after the completing bit; the drain wait covers it
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned FinalWait   = 2000;

  // parity selector codes the package leaves out
  localparam logic [1:0] ParityNone  = 2'd0;
  localparam logic [1:0] ParityAlias = 2'd3;

  typedef enum int unsigned {
    FaultNone,
    FaultParity,
    FaultStart,
    FaultStop
  } frame_fault_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_idx_t            cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                line_bit_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [DataW-1:0]    data_byte_o;

  // mirror of the layout registers and of the line-bit window
  cfg_t                layout_q;
  logic [WinLen-1:0]   window_q;
  int unsigned         fill_q;

  logic [DataW-1:0]    expected_bytes[$];
  int unsigned         bits_sent;
  int unsigned         mismatch_count;
  int unsigned         cycle_count;
  int unsigned         sender_idle_pct;
  int unsigned         receiver_idle_pct;

  uart_bit_frame_decoder_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .line_bit_i  (line_bit_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_byte_o (data_byte_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // run guard: a hang anywhere ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver side: drops ready at random, the rate is set per phase
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // effective frame layout: start/stop 0 reads as 1 and 3 as 2, data count
  // clamps to 5..8, selector 3 means no parity
  task automatic effective_layout(output int unsigned ns, output int unsigned nd,
                                  output int unsigned np, output int unsigned nst);
    ns  = (layout_q.start_bits == 2'd0) ? 1 : (layout_q.start_bits == 2'd3) ? 2 :
          layout_q.start_bits;
    nd  = (layout_q.data_bits < 4'd5) ? 5 : (layout_q.data_bits > 4'd8) ? 8 :
          layout_q.data_bits;
    np  = (layout_q.parity_mode == ParityOdd || layout_q.parity_mode == ParityEven) ? 1 : 0;
    nst = (layout_q.stop_bits == 2'd0) ? 1 : (layout_q.stop_bits == 2'd3) ? 2 :
          layout_q.stop_bits;
  endtask

  // shifts one line bit into the window and decides whether a frame completes
  task automatic decode_line_bit(input logic b, output logic hit,
                                 output logic [DataW-1:0] chr);
    int unsigned ns, nd, np, nst, len;
    logic        ok;
    logic        ones;
    effective_layout(ns, nd, np, nst);
    len = ns + nd + np + nst;
    hit = 1'b0;
    chr = '0;
    window_q = {window_q[WinLen-2:0], b};
    if (fill_q < WinLen) fill_q++;
    if (len <= WinLen && fill_q >= len) begin
      // oldest bit sits at window_q[len-1]; only the first start and stop count
      ok = !window_q[len-1] && window_q[len-1-(ns+nd+np)];
      ones = 1'b0;
      for (int unsigned k = 0; k < nd; k++) begin
        chr[k] = window_q[len-1-ns-k];
        ones ^= chr[k];
      end
      if (np != 0) begin
        ones ^= window_q[len-1-ns-nd];
        if (layout_q.parity_mode == ParityOdd && !ones) ok = 1'b0;
        if (layout_q.parity_mode == ParityEven && ones) ok = 1'b0;
      end
      if (ok) begin
        window_q = '0;
        fill_q = 0;
        hit = 1'b1;
      end
    end
  endtask

  // result check and prediction, both on the sampled edge
  always @(posedge clk_i) begin : check_results
    logic             hit;
    logic [DataW-1:0] chr;
    logic [DataW-1:0] want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_bytes.size() == 0) begin
          $error("data_byte: expected none, actual %02h", data_byte_o);
          mismatch_count++;
        end else begin
          want = expected_bytes.pop_front();
          if (data_byte_o !== want) begin
            $error("data_byte: expected %02h, actual %02h", want, data_byte_o);
            mismatch_count++;
          end
        end
      end
      // a byte from this request is only due next cycle, so push after the pop
      if (in_valid_i && in_ready_o) begin
        decode_line_bit(line_bit_i, hit, chr);
        if (hit) expected_bytes.push_back(chr);
      end
    end
  end

  // one line-bit request; returns on the falling edge after acceptance with
  // valid still high so back-to-back requests need no gap
  task automatic send_bit(input logic b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    line_bit_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    bits_sent++;
  endtask

  // one frame under the current layout; extra start and stop slots get noise
  task automatic send_frame(input logic [DataW-1:0] chr, input frame_fault_e fault);
    int unsigned ns, nd, np, nst;
    logic        par;
    effective_layout(ns, nd, np, nst);
    send_bit(fault == FaultStart);
    for (int unsigned k = 1; k < ns; k++) send_bit(1'($urandom_range(1)));
    par = 1'b0;
    for (int unsigned k = 0; k < nd; k++) begin
      send_bit(chr[k]);
      par ^= chr[k];
    end
    if (np != 0) begin
      // odd parity: the parity bit makes the total count of ones odd
      if (layout_q.parity_mode == ParityOdd) par = ~par;
      send_bit(par ^ (fault == FaultParity));
    end
    send_bit(fault != FaultStop);
    for (int unsigned k = 1; k < nst; k++) send_bit(1'($urandom_range(1)));
  endtask

  // holds the input off until every byte is out and the pipe is quiet
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // register write; the mirror follows at the edge that takes it
  task automatic write_reg(input cfg_idx_t idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      CfgStartBits:  layout_q.start_bits  = val[1:0];
      CfgDataBits:   layout_q.data_bits   = val;
      CfgParityMode: layout_q.parity_mode = val[1:0];
      CfgStopBits:   layout_q.stop_bits   = val[1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // new layout while idle; upper data bits of the 2-bit registers are junk
  task automatic load_layout(input cfg_t lay);
    wait_drained();
    write_reg(CfgStartBits, {2'($urandom_range(3)), lay.start_bits});
    write_reg(CfgDataBits, lay.data_bits);
    write_reg(CfgParityMode, {2'($urandom_range(3)), lay.parity_mode});
    write_reg(CfgStopBits, {2'($urandom_range(3)), lay.stop_bits});
    cfg_we_i <= 1'b0;
  endtask

  // reset layout: 1 start, 8 data, no parity, 1 stop
  task automatic test_reset_layout();
    send_frame(8'h00, FaultNone);
    send_frame(8'hFF, FaultNone);
    // low line where the stop bit should be: nothing may come out
    repeat (3) send_bit(1'b0);
  endtask

  // out-of-range counts, parity selector 3, shortest and longest frames
  task automatic test_layout_corners();
    cfg_t corners[9];
    corners[0] = '{start_bits: 2'd0, data_bits: 4'd0,  parity_mode: ParityOdd,   stop_bits: 2'd0};
    corners[1] = '{start_bits: 2'd3, data_bits: 4'd15, parity_mode: ParityEven,  stop_bits: 2'd3};
    corners[2] = '{start_bits: 2'd2, data_bits: 4'd4,  parity_mode: ParityAlias, stop_bits: 2'd2};
    corners[3] = '{start_bits: 2'd1, data_bits: 4'd9,  parity_mode: ParityOdd,   stop_bits: 2'd3};
    corners[4] = '{start_bits: 2'd3, data_bits: 4'd5,  parity_mode: ParityNone,  stop_bits: 2'd0};
    corners[5] = '{start_bits: 2'd1, data_bits: 4'd5,  parity_mode: ParityNone,  stop_bits: 2'd1};
    corners[6] = '{start_bits: 2'd2, data_bits: 4'd8,  parity_mode: ParityOdd,   stop_bits: 2'd2};
    corners[7] = '{start_bits: 2'd1, data_bits: 4'd6,  parity_mode: ParityEven,  stop_bits: 2'd1};
    corners[8] = '{start_bits: 2'd2, data_bits: 4'd7,  parity_mode: ParityNone,  stop_bits: 2'd1};
    foreach (corners[i]) begin
      load_layout(corners[i]);
      send_frame(8'($urandom), FaultNone);
      send_frame(8'($urandom), FaultParity);
      send_frame(8'($urandom), FaultNone);
      send_frame(8'($urandom), FaultStop);
      send_frame(8'($urandom), FaultStart);
      send_frame(8'($urandom), FaultNone);
    end
  endtask

  // half a frame under one layout, the rest under a narrower one
  task automatic test_cfg_midstream();
    load_layout('{start_bits: 2'd1, data_bits: 4'd8, parity_mode: ParityNone, stop_bits: 2'd1});
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    // window is kept; the next check reads the newest bits with the new layout
    load_layout('{start_bits: 2'd1, data_bits: 4'd5, parity_mode: ParityNone, stop_bits: 2'd1});
    send_bit(1'b1);
    send_bit(1'b0);
    send_bit(1'b1);
    send_bit(1'b1);
    send_frame(8'($urandom), FaultNone);
  endtask

  // mostly clean frames with random bytes, some broken frames and line noise;
  // the layout changes every so often
  task automatic test_random_layouts(input int unsigned tx_idle, input int unsigned rx_idle,
                                     input int unsigned n_bits, input cfg_t first);
    int unsigned stop_at;
    int unsigned seg_end;
    int unsigned pick;
    cfg_t        lay;
    sender_idle_pct   = tx_idle;
    receiver_idle_pct = rx_idle;
    load_layout(first);
    stop_at = bits_sent + n_bits;
    seg_end = bits_sent + 120;
    while (bits_sent < stop_at) begin
      if (bits_sent >= seg_end) begin
        lay.start_bits  = 2'($urandom_range(3));
        lay.data_bits   = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) :
                          4'($urandom_range(8, 5));
        lay.parity_mode = 2'($urandom_range(3));
        lay.stop_bits   = 2'($urandom_range(3));
        load_layout(lay);
        seg_end = bits_sent + 120;
      end
      pick = $urandom_range(99);
      if (pick < 70) send_frame(8'($urandom), FaultNone);
      else if (pick < 78) send_frame(8'($urandom), FaultParity);
      else if (pick < 84) send_frame(8'($urandom), FaultStart);
      else if (pick < 90) send_frame(8'($urandom), FaultStop);
      else repeat ($urandom_range(6, 1)) send_bit(1'($urandom_range(1)));
      // idle-high line between frames
      repeat ($urandom_range(2)) send_bit(1'b1);
    end
  endtask

  initial begin : main
    int unsigned waited;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_index_i       = CfgStartBits;
    cfg_data_i        = '0;
    in_valid_i        = 1'b0;
    line_bit_i        = 1'b0;
    out_ready_i       = 1'b0;
    layout_q          = CfgReset;
    window_q          = '0;
    fill_q            = 0;
    bits_sent         = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    sender_idle_pct   = 34;
    receiver_idle_pct = 72;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_layout();
    test_layout_corners();
    test_cfg_midstream();
    test_random_layouts(34, 72, 380,
      '{start_bits: 2'd2, data_bits: 4'd8, parity_mode: ParityEven, stop_bits: 2'd2});
    test_random_layouts(72, 34, 380,
      '{start_bits: 2'd1, data_bits: 4'd5, parity_mode: ParityNone, stop_bits: 2'd1});
    test_random_layouts(0, 0, 380,
      '{start_bits: 2'd2, data_bits: 4'd8, parity_mode: ParityOdd, stop_bits: 2'd2});

    // let the last bytes out, bounded
    in_valid_i <= 1'b0;
    waited = 0;
    while (expected_bytes.size() != 0 && waited < FinalWait) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (expected_bytes.size() != 0) begin
      $error("data_byte: expected %02h, actual none (%0d bytes missing)",
             expected_bytes[0], expected_bytes.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/ubfd_pkg.sv
src/ubfd_cell.sv
src/ubfd_check.sv
src/uart_bit_frame_decoder_core.sv
tb/sv/uart_bit_frame_decoder_core_tb.sv
